// File: hdl/ffs_pkg.sv
package ffs_pkg;

  localparam int unsigned SLOTS_DEF       = 16;
  localparam int unsigned FRAME_BYTES_DEF = 8;

  localparam int unsigned FRAME_W  = 64;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned STAMP_IN_W = 32;
  localparam int unsigned STAMP_W  = 24;
  localparam int unsigned STAT_W   = 5;
  localparam int unsigned OVF_W    = 16;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 2;

  localparam logic [OVF_W-1:0] OVF_MAX = '1;

  // s_axis tdata: frame_in, length_in, stamp_in, padded to whole bytes
  localparam int unsigned IN_DATA_BITS = FRAME_W + LEN_W + STAMP_IN_W;
  localparam int unsigned IN_DATA_W    = ((IN_DATA_BITS + 7) / 8) * 8;
  // m_axis tdata: frame_out, length_out, stamp_out, fill, high water, overflow
  localparam int unsigned OUT_DATA_BITS = FRAME_W + LEN_W + STAMP_W + 2 * STAT_W + OVF_W;
  localparam int unsigned OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  // bookkeeping of one item between acceptance and the memory read return
  typedef struct packed {
    status_e           status;
    logic              pop_ok;
    logic [STAT_W-1:0] fill;
    logic [STAT_W-1:0] high;
    logic [OVF_W-1:0]  ovf;
  } pend_t;

  typedef struct packed {
    status_e             status;
    logic [FRAME_W-1:0]  frame;
    logic [LEN_W-1:0]    len;
    logic [STAMP_W-1:0]  stamp;
    logic [STAT_W-1:0]   fill;
    logic [STAT_W-1:0]   high;
    logic [OVF_W-1:0]    ovf;
  } res_t;

  // keeps the first len bytes of a frame
  function automatic logic [FRAME_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [FRAME_W-1:0] m;
    m = '0;
    for (int i = 0; i < FRAME_W / 8; i++) begin
      if (LEN_W'(i) < len) begin
        m[i*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// File: hdl/ffs_ram.sv
module ffs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/frame_fifo_with_stats.sv
// frame_fifo_with_stats: ring queue of short frames with fill statistics.
// input channel s_axis: tuser carries the kind (push, pop, clear), tdata the
// frame bytes, their count and a timestamp of which the low 24 bits are kept.
// output channel m_axis: exactly one item per input item, in order; tuser is
// the status (ok, bad length, full, empty), tdata the popped frame, length and
// stamp (zero unless a pop succeeded) plus fill count, high-water mark and the
// saturating count of pushes refused for a full queue.
// frames, lengths and stamps live in one memory of SLOTS entries with a
// registered read port; pointers and statistics are flops updated when the
// item is accepted, so a pop reads its entry in the accept cycle and its result
// forms from the read data in the next cycle.
// a result passes from the pending register into the output register, or into
// the skid while m_axis stalls, and from there onto m_axis. the input is held
// off while an item waits for its read data and the output register is full;
// after a stall the block takes one more item and then waits for the skid to
// drain.
// reset: queue empty, statistics zero, no result pending; memory contents are
// left as they are and only written entries are ever read.
// a stalled m_axis holds its item stable; up to two results queue inside.
module frame_fifo_with_stats #(
  parameter int unsigned SLOTS       = ffs_pkg::SLOTS_DEF,
  parameter int unsigned FRAME_BYTES = ffs_pkg::FRAME_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // s_axis_tdata: frame_in[63:0], length_in[67:64], stamp_in[99:68], zero pad
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [ffs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // s_axis_tuser: kind[1:0]
  input  logic [ffs_pkg::KIND_W-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // m_axis_tdata: frame_out[63:0], length_out[67:64], stamp_out[91:68],
  // fill_count[96:92], high_water[101:97], overflow_count[117:102], zero pad
  output logic [ffs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // m_axis_tuser: status[1:0]
  output logic [ffs_pkg::STATUS_W-1:0]   m_axis_tuser
);

  import ffs_pkg::*;

  localparam int unsigned IDX_W   = $clog2(SLOTS);
  localparam int unsigned CNT_W   = $clog2(SLOTS + 1);
  localparam int unsigned SFRAME_W = FRAME_BYTES * 8;
  localparam int unsigned ENTRY_W = SFRAME_W + LEN_W + STAMP_W;

  // input fields
  kind_e                 kind;
  logic [FRAME_W-1:0]    frame_in;
  logic [LEN_W-1:0]      length_in;
  logic [STAMP_W-1:0]    stamp_in;

  assign kind      = kind_e'(s_axis_tuser);
  assign frame_in  = s_axis_tdata[FRAME_W-1:0];
  assign length_in = s_axis_tdata[FRAME_W +: LEN_W];
  assign stamp_in  = s_axis_tdata[FRAME_W + LEN_W +: STAMP_W];

  // queue pointers and statistics
  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] peak_q, peak_d;
  logic [OVF_W-1:0] ovf_q, ovf_d;

  // pending item waiting for its memory read, output register and skid
  logic  pend_valid_q;
  pend_t pend_q, pend_d;
  logic  out_valid_q, out_valid_d;
  res_t  out_q, out_d;
  logic  skid_valid_q, skid_valid_d;
  res_t  skid_q, skid_d;
  res_t  pend_res;

  logic               in_accept;
  logic               mem_we, mem_re;
  logic [ENTRY_W-1:0] mem_wdata, mem_rdata;
  logic               out_free;

  // the item in flight always finds room: either the output register frees or
  // the skid is empty
  assign s_axis_tready = !skid_valid_q && !(pend_valid_q && out_valid_q);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign mem_wdata = {stamp_in, length_in,
                      SFRAME_W'(frame_in & byte_mask(length_in))};

  // queue update on acceptance
  always_comb begin
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    count_d  = count_q;
    peak_d   = peak_q;
    ovf_d    = ovf_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    pend_d.status = ST_OK;
    pend_d.pop_ok = 1'b0;
    if (in_accept) begin
      unique case (kind)
        KIND_PUSH: begin
          if (length_in == '0 || length_in > LEN_W'(FRAME_BYTES)) begin
            pend_d.status = ST_BAD_LEN;
          end else if (count_q == CNT_W'(SLOTS)) begin
            pend_d.status = ST_FULL;
            if (ovf_q != OVF_MAX) begin
              ovf_d = ovf_q + 1'b1;
            end
          end else begin
            mem_we   = 1'b1;
            wr_idx_d = (wr_idx_q == IDX_W'(SLOTS - 1)) ? '0 : wr_idx_q + 1'b1;
            count_d  = count_q + 1'b1;
            if (count_d > peak_q) begin
              peak_d = count_d;
            end
          end
        end
        KIND_POP: begin
          if (count_q == '0) begin
            pend_d.status = ST_EMPTY;
          end else begin
            mem_re        = 1'b1;
            pend_d.pop_ok = 1'b1;
            rd_idx_d = (rd_idx_q == IDX_W'(SLOTS - 1)) ? '0 : rd_idx_q + 1'b1;
            count_d  = count_q - 1'b1;
          end
        end
        KIND_CLEAR: begin
          wr_idx_d = '0;
          rd_idx_d = '0;
          count_d  = '0;
          peak_d   = '0;
          ovf_d    = '0;
        end
        default: begin
        end
      endcase
    end
    pend_d.fill = STAT_W'(count_d);
    pend_d.high = STAT_W'(peak_d);
    pend_d.ovf  = ovf_d;
  end

  ffs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_idx_q),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_idx_q),
    .rdata_o (mem_rdata)
  );

  // result of the pending item; stored frames are already masked
  always_comb begin
    pend_res.status = pend_q.status;
    pend_res.fill   = pend_q.fill;
    pend_res.high   = pend_q.high;
    pend_res.ovf    = pend_q.ovf;
    if (pend_q.pop_ok) begin
      pend_res.frame = FRAME_W'(mem_rdata[SFRAME_W-1:0]);
      pend_res.len   = mem_rdata[SFRAME_W +: LEN_W];
      pend_res.stamp = mem_rdata[SFRAME_W + LEN_W +: STAMP_W];
    end else begin
      pend_res.frame = '0;
      pend_res.len   = '0;
      pend_res.stamp = '0;
    end
  end

  // output register with skid; skid and pending never hold items together
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_d       = pend_res;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (pend_valid_q) begin
      skid_valid_d = 1'b1;
      skid_d       = pend_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q     <= '0;
      rd_idx_q     <= '0;
      count_q      <= '0;
      peak_q       <= '0;
      ovf_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      wr_idx_q     <= wr_idx_d;
      rd_idx_q     <= rd_idx_d;
      count_q      <= count_d;
      peak_q       <= peak_d;
      ovf_q        <= ovf_d;
      pend_valid_q <= in_accept;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = OUT_DATA_W'({out_q.ovf, out_q.high, out_q.fill,
                                      out_q.stamp, out_q.len, out_q.frame});

endmodule
